### rtl/point_line_distance_top_macros.svh
// Assertion helpers for the point-to-line distance block
`ifndef POINT_LINE_DISTANCE_TOP_MACROS_SVH
`define POINT_LINE_DISTANCE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every edge
`define PLD_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pld_pkg.sv
// ----------------------------------------------------------------------------
// pld_pkg
// Shared types and constants of the point-to-line distance pipeline.
// ----------------------------------------------------------------------------
package pld_pkg;

   localparam int DIST_BITS = 25;
   localparam int QUOT_BITS = 2 * DIST_BITS;

   typedef struct packed {
      logic valid;
      logic degen;
      logic sat;
   } pld_ctl_type;

endpackage

### rtl/point_line_distance_top.sv
// ----------------------------------------------------------------------------
// point_line_distance_top
// Distance from a 3D point to the line through two points, fully pipelined.
// ----------------------------------------------------------------------------
// The req_ channel carries a query point and a line's start and end, signed
// fixed point with 8 fractional bits. The rsp_ channel returns the distance,
// truncated to 8 fractional bits, and a flag for a line whose ends coincide
// (distance then 0). Both channels use valid/ready; a transfer happens when
// both are high.
// The pipeline runs through differences and cross product, the squared
// norms, the divider (one quotient bit a stage plus the range check) and the
// square root (one root bit a stage plus its input).
// One item is accepted every cycle while rsp_ready stays high.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// req_ready drops; nothing is lost or repeated.
// Reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
`include "point_line_distance_top_macros.svh"

module point_line_distance_top
   import pld_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_point_z,
   input  logic signed [COORD_BITS-1:0] req_line_start_x,
   input  logic signed [COORD_BITS-1:0] req_line_start_y,
   input  logic signed [COORD_BITS-1:0] req_line_start_z,
   input  logic signed [COORD_BITS-1:0] req_line_end_x,
   input  logic signed [COORD_BITS-1:0] req_line_end_y,
   input  logic signed [COORD_BITS-1:0] req_line_end_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [DIST_BITS-1:0]         rsp_dist_res,
   output logic                         rsp_degenerate
);

   localparam int DW   = COORD_BITS + 1;
   localparam int CW   = 2 * DW + 1;
   localparam int NW   = 2 * DW + 2;
   localparam int NUMW = 2 * CW + 2;

   logic                 en;
   pld_ctl_type          front_ctl, sq_ctl, div_ctl, sqrt_ctl;
   logic [CW-1:0]        mag [3];
   logic [NW-1:0]        den, sq_den;
   logic [NUMW-1:0]      num;
   logic [QUOT_BITS-1:0] quot;

   assign en        = !sqrt_ctl.valid || rsp_ready;
   assign req_ready = en;

   pld_front #(.CB(COORD_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .px       (req_point_x),
      .py       (req_point_y),
      .pz       (req_point_z),
      .sx       (req_line_start_x),
      .sy       (req_line_start_y),
      .sz       (req_line_start_z),
      .ex       (req_line_end_x),
      .ey       (req_line_end_y),
      .ez       (req_line_end_z),
      .out_ctl  (front_ctl),
      .out_mag  (mag),
      .out_den  (den)
   );

   pld_square #(.CW(CW), .NW(NW)) u_square (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_ctl  (front_ctl),
      .in_mag  (mag),
      .in_den  (den),
      .out_ctl (sq_ctl),
      .out_num (num),
      .out_den (sq_den)
   );

   pld_div #(.NUMW(NUMW), .DENW(NW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (sq_ctl),
      .in_num   (num),
      .in_den   (sq_den),
      .out_ctl  (div_ctl),
      .out_quot (quot)
   );

   pld_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (div_ctl),
      .in_quot  (quot),
      .out_ctl  (sqrt_ctl),
      .out_root (rsp_dist_res)
   );

   assign rsp_valid      = sqrt_ctl.valid;
   assign rsp_degenerate = sqrt_ctl.degen;

   `PLD_ASSERT_NOW(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate, rsp_dist_res == '0, "degenerate line with nonzero distance")
   `PLD_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid, "result valid right after reset")
   `PLD_ASSERT_NOW(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, !req_ready, "input taken while output stalled")

endmodule

### rtl/pld_front.sv
// ----------------------------------------------------------------------------
// pld_front
// Difference vectors, cross product magnitudes and squared direction length.
// ----------------------------------------------------------------------------
module pld_front
   import pld_pkg::*;
#(
   parameter int CB = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [CB-1:0]     px,
   input  logic signed [CB-1:0]     py,
   input  logic signed [CB-1:0]     pz,
   input  logic signed [CB-1:0]     sx,
   input  logic signed [CB-1:0]     sy,
   input  logic signed [CB-1:0]     sz,
   input  logic signed [CB-1:0]     ex,
   input  logic signed [CB-1:0]     ey,
   input  logic signed [CB-1:0]     ez,
   output pld_ctl_type              out_ctl,
   output logic [2*CB+2:0]          out_mag [3],
   output logic [2*CB+3:0]          out_den
);

   localparam int DW = CB + 1;
   localparam int PW = 2 * DW;
   localparam int CW = PW + 1;
   localparam int NW = PW + 2;

   logic              v0_ff, v1_ff;
   pld_ctl_type       ctl2_ff;
   logic signed [DW-1:0] u_in [3];
   logic signed [DW-1:0] d_in [3];
   logic signed [DW-1:0] u_ff [3];
   logic signed [DW-1:0] d_ff [3];
   logic signed [PW-1:0] prod_in [6];
   logic signed [PW-1:0] prod_ff [6];
   logic signed [PW-1:0] sq_in [3];
   logic signed [PW-1:0] sq_ff [3];
   logic signed [CW-1:0] diff [3];
   logic [CW-1:0]        mag_in [3];
   logic [CW-1:0]        mag_ff [3];
   logic [NW-1:0]        den_in;
   logic [NW-1:0]        den_ff;

   always_comb begin
      u_in[0] = {px[CB-1], px} - {sx[CB-1], sx};
      u_in[1] = {py[CB-1], py} - {sy[CB-1], sy};
      u_in[2] = {pz[CB-1], pz} - {sz[CB-1], sz};
      d_in[0] = {ex[CB-1], ex} - {sx[CB-1], sx};
      d_in[1] = {ey[CB-1], ey} - {sy[CB-1], sy};
      d_in[2] = {ez[CB-1], ez} - {sz[CB-1], sz};
   end

   always_comb begin
      prod_in[0] = u_ff[1] * d_ff[2];
      prod_in[1] = d_ff[1] * u_ff[2];
      prod_in[2] = d_ff[0] * u_ff[2];
      prod_in[3] = u_ff[0] * d_ff[2];
      prod_in[4] = u_ff[0] * d_ff[1];
      prod_in[5] = d_ff[0] * u_ff[1];
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = d_ff[i] * d_ff[i];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = {prod_ff[2*i][PW-1], prod_ff[2*i]}
                 - {prod_ff[2*i+1][PW-1], prod_ff[2*i+1]};
         mag_in[i] = diff[i][CW-1] ? CW'(-diff[i]) : CW'(diff[i]);
      end
      den_in = NW'(unsigned'(sq_ff[0])) + NW'(unsigned'(sq_ff[1]))
             + NW'(unsigned'(sq_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         v1_ff   <= 1'b0;
         ctl2_ff <= '0;
      end else if (en) begin
         v0_ff         <= in_valid;
         v1_ff         <= v0_ff;
         ctl2_ff.valid <= v1_ff;
         ctl2_ff.degen <= (den_in == '0);
         ctl2_ff.sat   <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff    <= u_in;
         d_ff    <= d_in;
         prod_ff <= prod_in;
         sq_ff   <= sq_in;
         mag_ff  <= mag_in;
         den_ff  <= den_in;
      end
   end

   assign out_ctl = ctl2_ff;
   assign out_mag = mag_ff;
   assign out_den = den_ff;

endmodule

### rtl/pld_square.sv
// ----------------------------------------------------------------------------
// pld_square
// Squares the cross product magnitudes by split partial products and sums.
// ----------------------------------------------------------------------------
module pld_square
   import pld_pkg::*;
#(
   parameter int CW = 51,
   parameter int NW = 52
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  pld_ctl_type       in_ctl,
   input  logic [CW-1:0]     in_mag [3],
   input  logic [NW-1:0]     in_den,
   output pld_ctl_type       out_ctl,
   output logic [2*CW+1:0]   out_num,
   output logic [NW-1:0]     out_den
);

   localparam int L    = (CW + 1) / 2;
   localparam int H    = CW - L;
   localparam int SQW  = 2 * CW;
   localparam int NUMW = SQW + 2;

   pld_ctl_type       ctl_ff [3];
   logic [NW-1:0]     den_ff [3];
   logic [2*H-1:0]    hh_ff [3];
   logic [H+L-1:0]    hl_ff [3];
   logic [2*L-1:0]    ll_ff [3];
   logic [SQW-1:0]    sq_in [3];
   logic [SQW-1:0]    sq_ff [3];
   logic [NUMW-1:0]   num_in;
   logic [NUMW-1:0]   num_ff;
   logic [2*H-1:0]    hh_in [3];
   logic [H+L-1:0]    hl_in [3];
   logic [2*L-1:0]    ll_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hh_in[i] = (2*H)'(in_mag[i][CW-1:L]) * (2*H)'(in_mag[i][CW-1:L]);
         hl_in[i] = (H+L)'(in_mag[i][CW-1:L]) * (H+L)'(in_mag[i][L-1:0]);
         ll_in[i] = (2*L)'(in_mag[i][L-1:0]) * (2*L)'(in_mag[i][L-1:0]);
         sq_in[i] = (SQW'(hh_ff[i]) << (2*L)) + (SQW'(hl_ff[i]) << (L+1))
                  + SQW'(ll_ff[i]);
      end
      num_in = NUMW'(sq_ff[0]) + NUMW'(sq_ff[1]) + NUMW'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
         ctl_ff[1] <= '0;
         ctl_ff[2] <= '0;
      end else if (en) begin
         ctl_ff[0] <= in_ctl;
         ctl_ff[1] <= ctl_ff[0];
         ctl_ff[2] <= ctl_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0] <= in_den;
         den_ff[1] <= den_ff[0];
         den_ff[2] <= den_ff[1];
         hh_ff     <= hh_in;
         hl_ff     <= hl_in;
         ll_ff     <= ll_in;
         sq_ff     <= sq_in;
         num_ff    <= num_in;
      end
   end

   assign out_ctl = ctl_ff[2];
   assign out_num = num_ff;
   assign out_den = den_ff[2];

endmodule

### rtl/pld_div.sv
// ----------------------------------------------------------------------------
// pld_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module pld_div
   import pld_pkg::*;
#(
   parameter int NUMW = 104,
   parameter int DENW = 52
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  pld_ctl_type           in_ctl,
   input  logic [NUMW-1:0]       in_num,
   input  logic [DENW-1:0]       in_den,
   output pld_ctl_type           out_ctl,
   output logic [QUOT_BITS-1:0]  out_quot
);

   localparam int QB = QUOT_BITS;
   localparam int WW = (NUMW > DENW + QB) ? NUMW : DENW + QB;

   pld_ctl_type     ctl_ff [QB+1];
   logic [WW-1:0]   rem_ff [QB+1];
   logic [QB-1:0]   quo_ff [QB+1];
   logic [DENW-1:0] den_ff [QB+1];
   logic            sat_in;

   assign sat_in = WW'(in_num) >= (WW'(in_den) << QB);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0].valid <= in_ctl.valid;
         ctl_ff[0].degen <= in_ctl.degen;
         ctl_ff[0].sat   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= WW'(in_num);
         quo_ff[0] <= '0;
         den_ff[0] <= in_den;
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_step
      localparam int SH = QB - k;
      logic [WW-1:0] trial;
      logic          hit;

      assign trial = WW'(den_ff[k-1]) << SH;
      assign hit   = !ctl_ff[k-1].sat && (rem_ff[k-1] >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (en) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= hit ? rem_ff[k-1] - trial : rem_ff[k-1];
            quo_ff[k] <= quo_ff[k-1] | (hit ? (QB'(1) << SH) : '0);
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign out_ctl  = ctl_ff[QB];
   assign out_quot = ctl_ff[QB].sat ? '1 : quo_ff[QB];

endmodule

### rtl/pld_sqrt.sv
// ----------------------------------------------------------------------------
// pld_sqrt
// Pipelined integer square root, one root bit per stage; last stage is output.
// ----------------------------------------------------------------------------
module pld_sqrt
   import pld_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  pld_ctl_type           in_ctl,
   input  logic [QUOT_BITS-1:0]  in_quot,
   output pld_ctl_type           out_ctl,
   output logic [DIST_BITS-1:0]  out_root
);

   localparam int XW = QUOT_BITS;
   localparam int RW = XW + 1;
   localparam int RB = DIST_BITS;

   pld_ctl_type   ctl_ff [RB+1];
   logic [XW-1:0] x_ff [RB+1];
   logic [RW-1:0] r_ff [RB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= in_quot;
         r_ff[0] <= '0;
      end
   end

   for (genvar s = 0; s < RB; s++) begin : g_step
      localparam int SH = 2 * (RB - 1 - s);
      logic [RW-1:0] bitv;
      logic [RW-1:0] sum;
      logic          ge;

      assign bitv = RW'(1) << SH;
      assign sum  = r_ff[s] + bitv;
      assign ge   = RW'(x_ff[s]) >= sum;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s+1] <= '0;
         end else if (en) begin
            ctl_ff[s+1] <= ctl_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[s+1] <= ge ? XW'(RW'(x_ff[s]) - sum) : x_ff[s];
            r_ff[s+1] <= ge ? (r_ff[s] >> 1) + bitv : r_ff[s] >> 1;
         end
      end
   end

   assign out_ctl  = ctl_ff[RB];
   assign out_root = ctl_ff[RB].degen ? '0 : r_ff[RB][RB-1:0];

endmodule

### tb/tb_point_line_distance_top.sv
// ----------------------------------------------------------------------------
// tb_point_line_distance_top
// Self-checking bench for the point-to-line distance pipeline.
// ----------------------------------------------------------------------------
// A driver offers queued queries on the req_ channel with random gaps. A
// predictor computes the exact truncated distance for each query at the
// transfer. A monitor compares each rsp_ transfer with the oldest expected
// distance while the receiver stalls at random, once for a long stretch.
// ----------------------------------------------------------------------------
module tb_point_line_distance_top
   import pld_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = 24;
   localparam int LATENCY = 83;
   localparam int WATCHDOG = 20000;

   typedef logic signed [CB-1:0] coord_type;
   typedef struct {
      coord_type c[9];
   } query_type;
   typedef struct {
      logic [DIST_BITS-1:0] dist_res;
      logic                 degen;
   } distance_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   coord_type req_c[9] = '{default: '0};
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [DIST_BITS-1:0] rsp_dist_res;
   logic rsp_degenerate;

   query_type pending_queries[$];
   distance_type expected_distances[$];
   int failures = 0;
   int idle_cycles = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   int rsp_count = 0;
   bit stim_done = 0;
   bit req_taken = 0;

   always #2 clock = ~clock;

   point_line_distance_top #(.COORD_BITS(CB)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_x(req_c[0]), .req_point_y(req_c[1]), .req_point_z(req_c[2]),
      .req_line_start_x(req_c[3]), .req_line_start_y(req_c[4]),
      .req_line_start_z(req_c[5]),
      .req_line_end_x(req_c[6]), .req_line_end_y(req_c[7]),
      .req_line_end_z(req_c[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_dist_res(rsp_dist_res), .rsp_degenerate(rsp_degenerate));

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x = x - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic distance_type line_distance(query_type q);
      logic signed [31:0] u[3];
      logic signed [31:0] d[3];
      logic signed [70:0] cr[3];
      logic [143:0] num;
      logic [143:0] den;
      logic [143:0] quot;
      distance_type r;
      for (int i = 0; i < 3; i++) begin
         u[i] = 32'(q.c[i]) - 32'(q.c[3+i]);
         d[i] = 32'(q.c[6+i]) - 32'(q.c[3+i]);
      end
      cr[0] = 71'(u[1]) * 71'(d[2]) - 71'(d[1]) * 71'(u[2]);
      cr[1] = 71'(d[0]) * 71'(u[2]) - 71'(u[0]) * 71'(d[2]);
      cr[2] = 71'(u[0]) * 71'(d[1]) - 71'(d[0]) * 71'(u[1]);
      den = 0;
      num = 0;
      for (int i = 0; i < 3; i++) begin
         den += 144'(144'(signed'(d[i])) * 144'(signed'(d[i])));
         num += 144'(144'(signed'(cr[i])) * 144'(signed'(cr[i])));
      end
      if (den == 0) begin
         r.dist_res = '0;
         r.degen = 1;
      end else begin
         quot = num / den;
         r.degen = 0;
         if (quot >= (144'd1 << QUOT_BITS)) r.dist_res = '1;
         else r.dist_res = DIST_BITS'(floor_sqrt(quot[63:0]));
      end
      return r;
   endfunction

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'(int'($urandom_range(0, 2047)) - 1024);
         2: return coord_type'({1'b1, {(CB-1){1'b0}}});
         3: return coord_type'({1'b0, {(CB-1){1'b1}}});
         default: return coord_type'(int'($urandom_range(0, 65535)) - 32768);
      endcase
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
      return $urandom_range(0, 3);
   endfunction

   initial begin
      query_type q;
      int mode;
      coord_type ext[4];
      ext[0] = coord_type'({1'b1, {(CB-1){1'b0}}});
      ext[1] = coord_type'({1'b0, {(CB-1){1'b1}}});
      ext[2] = '0;
      ext[3] = '1;
      for (int k = 0; k < 16; k++) begin
         foreach (q.c[i]) q.c[i] = ext[(k + i * (k / 4 + 1)) % 4];
         pending_queries.push_back(q);
      end
      foreach (q.c[i]) q.c[i] = ext[1];
      for (int i = 3; i < 6; i++) q.c[i] = ext[0];
      pending_queries.push_back(q);
      foreach (q.c[i]) q.c[i] = ext[0];
      for (int i = 3; i < 6; i++) q.c[i] = ext[1];
      pending_queries.push_back(q);
      for (int k = 0; k < 3; k++) begin
         foreach (q.c[i]) q.c[i] = rand_coord(0);
         for (int i = 0; i < 3; i++) q.c[6+i] = q.c[3+i];
         pending_queries.push_back(q);
      end
      foreach (q.c[i]) q.c[i] = rand_coord(0);
      for (int i = 0; i < 3; i++) q.c[i] = q.c[3+i];
      pending_queries.push_back(q);
      for (int k = 0; k < 800; k++) begin
         mode = $urandom_range(0, 4);
         foreach (q.c[i]) q.c[i] = ($urandom_range(0, 9) == 0) ?
            rand_coord($urandom_range(2, 3)) : rand_coord(mode);
         if ($urandom_range(0, 24) == 0)
            for (int i = 0; i < 3; i++) q.c[6+i] = q.c[3+i];
         pending_queries.push_back(q);
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            void'(pending_queries.pop_front());
            req_gap = pick_gap();
         end
         if (req_valid && !req_taken) begin
         end else if (req_gap > 0) begin
            req_valid <= 0;
            req_gap = req_gap - 1;
         end else if (pending_queries.size() > 0) begin
            req_valid <= 1;
            foreach (req_c[i]) req_c[i] <= pending_queries[0].c[i];
         end else begin
            req_valid <= 0;
            stim_done = 1;
         end
         req_taken = 0;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_gap > 0) begin
            rsp_ready <= 0;
            rsp_gap = rsp_gap - 1;
         end else begin
            rsp_ready <= 1;
            if (rsp_count == 40) rsp_gap = 300;
            else rsp_gap = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      distance_type exp_d;
      if (!reset) begin
         idle_cycles = idle_cycles + 1;
         if (req_valid && req_ready) begin
            expected_distances.push_back(line_distance(pending_queries[0]));
            req_taken = 1;
            idle_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            rsp_count = rsp_count + 1;
            if (expected_distances.size() == 0) begin
               $error("unexpected transfer dist_res=%0d", rsp_dist_res);
               failures = failures + 1;
            end else begin
               exp_d = expected_distances.pop_front();
               if (rsp_dist_res !== exp_d.dist_res) begin
                  $error("dist_res expected %0d actual %0d", exp_d.dist_res,
                         rsp_dist_res);
                  failures = failures + 1;
               end
               if (rsp_degenerate !== exp_d.degen) begin
                  $error("degenerate expected %0d actual %0d", exp_d.degen,
                         rsp_degenerate);
                  failures = failures + 1;
               end
            end
         end
      end
   end

   initial begin
      wait (stim_done && expected_distances.size() == 0);
      repeat (2 * LATENCY) @(posedge clock);
      if (failures == 0 && expected_distances.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG);
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

### sim.f
+incdir+rtl
rtl/pld_pkg.sv
rtl/pld_front.sv
rtl/pld_square.sv
rtl/pld_div.sv
rtl/pld_sqrt.sv
rtl/point_line_distance_top.sv
tb/tb_point_line_distance_top.sv
